// ===== sv/pfa_pkg.sv =====
// Package with shared constants, types and command structures of the page allocator.
`timescale 1ns / 1ps
package pfa_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int MAX_RUN     = 64;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int ADDR_W      = 32;
  localparam int COUNT_W     = 7;
  localparam int PSIZE_W     = 21;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    CMD_FREE  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NORUN = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_FULL,
    RES_EMPTY,
    RES_NORUN,
    RES_POP,
    RES_RUN,
    RES_HIT
  } res_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_TOP,
    RD_I,
    RD_K
  } rd_sel_e;

  typedef struct packed {
    logic    cap;
    logic    free_step;
    rd_sel_e rd_sel;
    logic    pop;
    logic    i_clr;
    logic    i_inc;
    logic    k_init;
    logic    k_dec;
    logic    cand_ld;
    logic    j_step;
    logic    tgt_base;
    logic    keep;
    logic    w_clr;
    logic    fc_w;
    logic    res_ld;
    res_e    res;
    logic    out_ld;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic overflow;
    logic cnt_zero;
    logic cnt_le1;
    logic cnt_big;
    logic fc_zero;
    logic match;
    logic j_last;
    logic i_last;
    logic k_zero;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== sv/page_free_list_allocator.sv =====
// Top level of the page allocator: controller, datapath and stream ports.
// Each transaction yields one result and the block takes one transaction at a time.
// A free stores its n pages in turn, a single-page allocate pops the newest page and a query
// compares the stored pages in turn. A multi-page allocate of n pages walks candidates
// from newest to oldest and searches the store for each page of a candidate run; all of
// these share the single read port of the store memory.
`timescale 1ns / 1ps
module page_free_list_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // cmd[1:0], addr[33:2], count[40:34], zero fill.
  input  logic [pfa_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // page_addr[31:0], is_free[32], status[34:33], zero fill.
  output logic [pfa_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pfa_pkg::PSIZE_W-1:0]     cfg_data_i
);
  import pfa_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  assign cfg_ready_o = 1'b1;

  pfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  pfa_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .in_data_i   (s_axis_tdata_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

// ===== sv/pfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pfa_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pfa_datapath.sv =====
// Datapath of the page allocator: store memory, counters, address registers and results.
`timescale 1ns / 1ps
module pfa_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pfa_pkg::dp_cmd_t                cmd_i,
  output pfa_pkg::dp_stat_t               stat_o,
  input  logic [pfa_pkg::IN_TDATA_W-1:0]  in_data_i,
  input  logic                            cfg_we_i,
  input  logic [pfa_pkg::PSIZE_W-1:0]     cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [pfa_pkg::OUT_TDATA_W-1:0] out_data_o
);
  import pfa_pkg::*;

  localparam logic [CNT_W:0] DepthL = (CNT_W + 1)'(STORE_DEPTH);

  logic [PSIZE_W-1:0] psize_q;
  cmd_e               cmd_q;
  logic [COUNT_W-1:0] count_q, j_q;
  logic [ADDR_W-1:0]  tgt_q, base_q;
  logic [CNT_W-1:0]   fc_q, w_q;
  logic [IDX_W-1:0]   i_q, k_q;
  logic [ADDR_W-1:0]  pend_page_q, out_page_q;
  logic               pend_free_q, out_free_q;
  status_e            pend_st_q, out_st_q;
  logic               out_valid_q;

  logic               we, re;
  logic [IDX_W-1:0]   waddr, raddr, top;
  logic [ADDR_W-1:0]  wdata, rdata, tgt_nx;

  assign top    = IDX_W'(fc_q - CNT_W'(1));
  assign tgt_nx = tgt_q + ADDR_W'(psize_q);

  always_comb begin
    we    = cmd_i.free_step | cmd_i.keep;
    waddr = cmd_i.keep ? w_q[IDX_W-1:0] : fc_q[IDX_W-1:0];
    wdata = cmd_i.keep ? rdata : tgt_q;
    re    = cmd_i.rd_sel != RD_NONE;
    case (cmd_i.rd_sel)
      RD_TOP:  raddr = top;
      RD_I:    raddr = i_q;
      RD_K:    raddr = k_q;
      default: raddr = '0;
    endcase
  end

  pfa_ram #(.Width(ADDR_W), .Depth(STORE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psize_q     <= PSIZE_W'(4096);
      fc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        psize_q <= cfg_data_i;
      end
      if (cmd_i.free_step) begin
        fc_q <= fc_q + CNT_W'(1);
      end else if (cmd_i.pop) begin
        fc_q <= fc_q - CNT_W'(1);
      end else if (cmd_i.fc_w) begin
        fc_q <= w_q;
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      cmd_q   <= cmd_e'(in_data_i[1:0]);
      tgt_q   <= in_data_i[33:2];
      count_q <= in_data_i[40:34];
      j_q     <= '0;
    end else if (cmd_i.free_step || cmd_i.j_step) begin
      tgt_q <= tgt_nx;
      j_q   <= j_q + COUNT_W'(1);
    end else if (cmd_i.cand_ld) begin
      base_q <= rdata;
      tgt_q  <= rdata;
      j_q    <= '0;
    end else if (cmd_i.tgt_base) begin
      tgt_q <= base_q;
      j_q   <= '0;
    end
    if (cmd_i.i_clr || cmd_i.cand_ld) begin
      i_q <= '0;
    end else if (cmd_i.i_inc) begin
      i_q <= i_q + IDX_W'(1);
    end
    if (cmd_i.k_init) begin
      k_q <= top;
    end else if (cmd_i.k_dec) begin
      k_q <= k_q - IDX_W'(1);
    end
    if (cmd_i.w_clr) begin
      w_q <= '0;
    end else if (cmd_i.keep) begin
      w_q <= w_q + CNT_W'(1);
    end
    if (cmd_i.res_ld) begin
      pend_page_q <= (cmd_i.res == RES_POP) ? rdata :
                     (cmd_i.res == RES_RUN) ? base_q : '0;
      pend_free_q <= cmd_i.res == RES_HIT;
      case (cmd_i.res)
        RES_FULL:  pend_st_q <= ST_FULL;
        RES_EMPTY: pend_st_q <= ST_EMPTY;
        RES_NORUN: pend_st_q <= ST_NORUN;
        default:   pend_st_q <= ST_OK;
      endcase
    end
    if (cmd_i.out_ld) begin
      out_page_q <= pend_page_q;
      out_free_q <= pend_free_q;
      out_st_q   <= pend_st_q;
    end
  end

  always_comb begin
    stat_o.cmd      = cmd_q;
    stat_o.overflow = ({1'b0, fc_q} + (CNT_W + 1)'(count_q)) > DepthL;
    stat_o.cnt_zero = count_q == '0;
    stat_o.cnt_le1  = count_q <= COUNT_W'(1);
    stat_o.cnt_big  = int'(count_q) > MAX_RUN;
    stat_o.fc_zero  = fc_q == '0;
    stat_o.match    = rdata == tgt_q;
    stat_o.j_last   = j_q == count_q - COUNT_W'(1);
    stat_o.i_last   = i_q == top;
    stat_o.k_zero   = k_q == '0;
    stat_o.out_busy = out_valid_q & ~out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {5'b0, out_st_q, out_free_q, out_page_q};

endmodule

// ===== sv/pfa_ctrl.sv =====
// Controller state machine that sequences free, pop, query, search and compaction.
`timescale 1ns / 1ps
module pfa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pfa_pkg::dp_stat_t  stat_i,
  output pfa_pkg::dp_cmd_t   cmd_o
);
  import pfa_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001,
    S_DECODE = 15'h0002,
    S_FREE   = 15'h0004,
    S_POP_RD = 15'h0008,
    S_POP_WT = 15'h0010,
    S_Q_RD   = 15'h0020,
    S_Q_CMP  = 15'h0040,
    S_C_RD   = 15'h0080,
    S_C_LD   = 15'h0100,
    S_S_RD   = 15'h0200,
    S_S_CMP  = 15'h0400,
    S_K_RD   = 15'h0800,
    S_K_CMP  = 15'h1000,
    S_K_NX   = 15'h2000,
    S_RES    = 15'h4000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RD_NONE;
    cmd_o.res    = RES_ZERO;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d      = S_RES;
        cmd_o.res_ld = 1'b1;
        unique case (stat_i.cmd)
          CMD_FREE: begin
            if (stat_i.overflow) begin
              cmd_o.res = RES_FULL;
            end else if (!stat_i.cnt_zero) begin
              cmd_o.res_ld = 1'b0;
              state_d      = S_FREE;
            end
          end
          CMD_ALLOC: begin
            if (stat_i.fc_zero) begin
              cmd_o.res = RES_EMPTY;
            end else if (stat_i.cnt_le1) begin
              cmd_o.res_ld = 1'b0;
              state_d      = S_POP_RD;
            end else if (stat_i.cnt_big) begin
              cmd_o.res = RES_NORUN;
            end else begin
              cmd_o.res_ld = 1'b0;
              cmd_o.k_init = 1'b1;
              state_d      = S_C_RD;
            end
          end
          CMD_QUERY: begin
            if (!stat_i.fc_zero) begin
              cmd_o.res_ld = 1'b0;
              cmd_o.i_clr  = 1'b1;
              state_d      = S_Q_RD;
            end
          end
          default: ;
        endcase
      end
      S_FREE: begin
        cmd_o.free_step = 1'b1;
        if (stat_i.j_last) begin
          cmd_o.res_ld = 1'b1;
          state_d      = S_RES;
        end
      end
      S_POP_RD: begin
        cmd_o.rd_sel = RD_TOP;
        state_d      = S_POP_WT;
      end
      S_POP_WT: begin
        cmd_o.pop    = 1'b1;
        cmd_o.res_ld = 1'b1;
        cmd_o.res    = RES_POP;
        state_d      = S_RES;
      end
      S_Q_RD: begin
        cmd_o.rd_sel = RD_I;
        state_d      = S_Q_CMP;
      end
      S_Q_CMP: begin
        if (stat_i.match) begin
          cmd_o.res_ld = 1'b1;
          cmd_o.res    = RES_HIT;
          state_d      = S_RES;
        end else if (stat_i.i_last) begin
          cmd_o.res_ld = 1'b1;
          state_d      = S_RES;
        end else begin
          cmd_o.i_inc = 1'b1;
          state_d     = S_Q_RD;
        end
      end
      S_C_RD: begin
        cmd_o.rd_sel = RD_K;
        state_d      = S_C_LD;
      end
      S_C_LD: begin
        cmd_o.cand_ld = 1'b1;
        state_d       = S_S_RD;
      end
      S_S_RD: begin
        cmd_o.rd_sel = RD_I;
        state_d      = S_S_CMP;
      end
      S_S_CMP: begin
        if (stat_i.match && stat_i.j_last) begin
          cmd_o.w_clr = 1'b1;
          cmd_o.i_clr = 1'b1;
          state_d     = S_K_RD;
        end else if (stat_i.match) begin
          cmd_o.j_step = 1'b1;
          cmd_o.i_clr  = 1'b1;
          state_d      = S_S_RD;
        end else if (stat_i.i_last) begin
          if (stat_i.k_zero) begin
            cmd_o.res_ld = 1'b1;
            cmd_o.res    = RES_NORUN;
            state_d      = S_RES;
          end else begin
            cmd_o.k_dec = 1'b1;
            state_d     = S_C_RD;
          end
        end else begin
          cmd_o.i_inc = 1'b1;
          state_d     = S_S_RD;
        end
      end
      S_K_RD: begin
        cmd_o.rd_sel   = RD_I;
        cmd_o.tgt_base = 1'b1;
        state_d        = S_K_CMP;
      end
      S_K_CMP: begin
        if (stat_i.match) begin
          state_d = S_K_NX;
        end else if (stat_i.j_last) begin
          cmd_o.keep = 1'b1;
          state_d    = S_K_NX;
        end else begin
          cmd_o.j_step = 1'b1;
        end
      end
      S_K_NX: begin
        if (stat_i.i_last) begin
          cmd_o.fc_w   = 1'b1;
          cmd_o.res_ld = 1'b1;
          cmd_o.res    = RES_RUN;
          state_d      = S_RES;
        end else begin
          cmd_o.i_inc = 1'b1;
          state_d     = S_K_RD;
        end
      end
      S_RES: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== sv/pfa_checker.sv =====
// Port-level checker of the page allocator and its bind to the top level.
`timescale 1ns / 1ps
module pfa_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [pfa_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result transaction dropped or changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second transaction accepted while one is in work");

  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[32] |->
      m_axis_tdata_o[34:33] == 2'd0 && m_axis_tdata_o[31:0] == 32'd0)
    else $error("query hit carries an address or an error status");

endmodule

bind page_free_list_allocator pfa_checker u_pfa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
